// ===== design/dll_pkg.sv =====
// Shared types, constants and command structures of the linked list engine.
`timescale 1ns / 1ps

package dll_pkg;

	// Pool size and the widths that follow from it.
	localparam int CAPACITY = 16;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int OP_W     = 2;
	localparam int STS_W    = 2;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  count_t;

	// Request operations.
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_HEAD = 2'd0,
		OP_PUSH_TAIL = 2'd1,
		OP_POP_HEAD  = 2'd2,
		OP_REMOVE_AT = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [STS_W-1:0] {
		STS_DONE    = 2'd0,
		STS_FULL    = 2'd1,
		STS_EMPTY   = 2'd2,
		STS_BAD_POS = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_WALK,
		S_UNLINK,
		S_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_req;
		logic check;
		logic do_insert;
		logic walk_start;
		logic walk_step;
		logic do_unlink;
		logic load_out;
	} dll_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_error;
		logic is_insert;
		logic found;
	} dll_flags_t;

endpackage

// ===== design/dll_req_if.sv =====
// Request channel interface: valid/ready handshake with the request payload.
`timescale 1ns / 1ps

interface dll_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        operation;
	logic signed [31:0] value;
	logic [4:0]        position;

	modport source (output valid, output operation, output value, output position,
		input ready);
	modport sink (input valid, input operation, input value, input position,
		output ready);
endinterface

// ===== design/dll_rsp_if.sv =====
// Response channel interface: valid/ready handshake with the result payload.
`timescale 1ns / 1ps

interface dll_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] removed_value;
	logic [4:0]         length;

	modport source (output valid, output status, output removed_value, output length,
		input ready);
	modport sink (input valid, input status, input removed_value, input length,
		output ready);
endinterface

// ===== design/dll_datapath.sv =====
// Datapath of the linked list engine: node memories, free-slot stack, list registers.
`timescale 1ns / 1ps

module dll_datapath
	import dll_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  dll_cmd_t                  cmd,
	output dll_flags_t                flags,
	input  logic [OP_W-1:0]           operation,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [CNT_W-1:0]          position,
	output logic [STS_W-1:0]          status,
	output logic signed [VALUE_W-1:0] removed_value,
	output logic [CNT_W-1:0]          length
);

	// Node pool memories.
	logic [VALUE_W-1:0] val_mem  [CAPACITY];
	logic [SLOT_W-1:0]  next_mem [CAPACITY];
	logic [SLOT_W-1:0]  prev_mem [CAPACITY];

	// Free-slot stack, one flop row per entry.
	slot_t free_q [CAPACITY];

	// List description.
	slot_t  head_q;
	slot_t  tail_q;
	count_t count_q;

	// Latched request.
	op_t                op_q;
	logic [VALUE_W-1:0] value_q;
	count_t             pos_q;

	// Walk state and registered memory reads.
	slot_t              cur_q;
	slot_t              cur_d;
	count_t             k_q;
	logic [VALUE_W-1:0] val_rd_q;
	slot_t              next_rd_q;
	slot_t              prev_rd_q;

	// Result and output registers.
	status_t            res_status_q;
	logic [VALUE_W-1:0] res_removed_q;
	status_t            out_status_q;
	logic [VALUE_W-1:0] out_removed_q;
	count_t             out_length_q;

	// Write ports of the memories.
	logic               val_we;
	logic               next_we;
	logic               prev_we;
	slot_t              next_wa;
	slot_t              next_wd;
	slot_t              prev_wa;
	slot_t              prev_wd;

	status_t            chk_status;
	slot_t              grab_slot;
	slot_t              give_idx;
	logic               is_insert;
	logic               middle;
	count_t             cnt_cap;
	count_t             cnt_top;

	assign is_insert = (op_q == OP_PUSH_HEAD) || (op_q == OP_PUSH_TAIL);
	assign cnt_cap   = count_t'(CAPACITY);
	assign cnt_top   = count_t'(CAPACITY - 1);

	// Top of the free stack before an insert, and the stack entry that takes the slot freed by a removal.
	assign grab_slot = free_q[SLOT_W'(cnt_top - count_q)];
	assign give_idx  = SLOT_W'(cnt_cap - count_q);

	// Request checks: full pool, empty list, position zero or past the end.
	always_comb begin
		chk_status = STS_DONE;
		if (is_insert) begin
			if (count_q == cnt_cap) chk_status = STS_FULL;
		end else if (count_q == '0) begin
			chk_status = STS_EMPTY;
		end else if ((pos_q == '0) || (pos_q > count_q)) begin
			chk_status = STS_BAD_POS;
		end
	end

	assign flags.is_error  = (chk_status != STS_DONE);
	assign flags.is_insert = is_insert;
	assign flags.found     = (k_q == pos_q);

	// Removal from the middle splices the neighbors together.
	assign middle = (count_q != count_t'(1)) && (pos_q != count_t'(1)) && (pos_q != count_q);

	// Memory write selection.
	always_comb begin
		val_we  = cmd.do_insert;
		next_we = 1'b0;
		prev_we = 1'b0;
		next_wa = grab_slot;
		next_wd = head_q;
		prev_wa = head_q;
		prev_wd = grab_slot;
		if (cmd.do_insert && (count_q != '0)) begin
			if (op_q == OP_PUSH_HEAD) begin
				next_we = 1'b1;
				next_wa = grab_slot;
				next_wd = head_q;
				prev_we = 1'b1;
				prev_wa = head_q;
				prev_wd = grab_slot;
			end else begin
				next_we = 1'b1;
				next_wa = tail_q;
				next_wd = grab_slot;
				prev_we = 1'b1;
				prev_wa = grab_slot;
				prev_wd = tail_q;
			end
		end else if (cmd.do_unlink && middle) begin
			next_we = 1'b1;
			next_wa = prev_rd_q;
			next_wd = next_rd_q;
			prev_we = 1'b1;
			prev_wa = next_rd_q;
			prev_wd = prev_rd_q;
		end
	end

	// Read address follows the slot being visited next.
	always_comb begin
		cur_d = cur_q;
		if (cmd.walk_start) begin
			cur_d = head_q;
		end else if (cmd.walk_step) begin
			cur_d = next_rd_q;
		end
	end

	// Node memories with registered read data.
	always_ff @(posedge clk) begin
		if (val_we) val_mem[grab_slot] <= value_q;
		if (next_we) next_mem[next_wa] <= next_wd;
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		val_rd_q  <= val_mem[cur_d];
		next_rd_q <= next_mem[cur_d];
		prev_rd_q <= prev_mem[cur_d];
	end

	// Request latch, walk counter and result payload.
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			op_q    <= op_t'(operation);
			value_q <= value;
			pos_q   <= (op_t'(operation) == OP_POP_HEAD) ? count_t'(1) : position;
		end
		cur_q <= cur_d;
		if (cmd.walk_start) begin
			k_q <= count_t'(1);
		end else if (cmd.walk_step) begin
			k_q <= k_q + count_t'(1);
		end
		if (cmd.check) begin
			res_status_q  <= chk_status;
			res_removed_q <= '0;
		end else if (cmd.do_unlink) begin
			res_removed_q <= val_rd_q;
		end
		if (cmd.load_out) begin
			out_status_q  <= res_status_q;
			out_removed_q <= res_removed_q;
			out_length_q  <= count_q;
		end
	end

	// List registers and free-slot stack.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				free_q[i] <= SLOT_W'(CAPACITY - 1 - i);
			end
		end else if (cmd.do_insert) begin
			count_q <= count_q + count_t'(1);
			if (count_q == '0) begin
				head_q <= grab_slot;
				tail_q <= grab_slot;
			end else if (op_q == OP_PUSH_HEAD) begin
				head_q <= grab_slot;
			end else begin
				tail_q <= grab_slot;
			end
		end else if (cmd.do_unlink) begin
			count_q          <= count_q - count_t'(1);
			free_q[give_idx] <= cur_q;
			if (count_q == count_t'(1)) begin
				head_q <= '0;
				tail_q <= '0;
			end else if (pos_q == count_t'(1)) begin
				head_q <= next_rd_q;
			end else if (pos_q == count_q) begin
				tail_q <= prev_rd_q;
			end
		end
	end

	assign status        = out_status_q;
	assign removed_value = out_removed_q;
	assign length        = out_length_q;

`ifndef ASSERT_OFF
	// The list never holds more nodes than the pool.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_cap)
		else $error("node count exceeds pool capacity");

	// An insert grows the list by exactly one node.
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_insert |=> count_q == $past(count_q) + count_t'(1))
		else $error("insert did not grow the list by one");

	// The walk never runs past the requested position.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> k_q < pos_q)
		else $error("walk passed the requested position");
`endif

endmodule

// ===== design/dll_ctrl.sv =====
// Controller state machine of the linked list engine.
`timescale 1ns / 1ps

module dll_ctrl
	import dll_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dll_flags_t flags,
	output dll_cmd_t   cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_req = 1'b1;
					state_d       = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (flags.is_error) begin
					state_d = S_RESP;
				end else if (flags.is_insert) begin
					cmd.do_insert = 1'b1;
					state_d       = S_RESP;
				end else begin
					cmd.walk_start = 1'b1;
					state_d        = S_WALK;
				end
			end
			S_WALK: begin
				if (flags.found) begin
					state_d = S_UNLINK;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			S_UNLINK: begin
				cmd.do_unlink = 1'b1;
				state_d       = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	// A loaded result is offered in the following cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not offered");

	// Waiting in the response state means the output register is occupied and stalled.
	a_resp_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && !cmd.load_out) |-> (out_valid_q && !out_ready))
		else $error("response state stalled without cause");
`endif

endmodule

// ===== design/doubly_linked_list_engine_top.sv =====
// Top level of the doubly linked list engine: controller, datapath and channel wiring.
`timescale 1ns / 1ps

// A bounded doubly linked list of signed 32-bit values in a pool of 16 slots.
// Each request item inserts at the head, appends at the tail, removes the head,
// or removes the node at a 1-based position, and returns one result item with a
// status, the removed value (zero if none) and the list length afterwards. One
// request is in work at a time. An insert, an append or a rejected request goes from the
// check state to the response state and is loaded into the result register once the
// output register is free; removing the node at position p walks to it one next link
// per cycle through the registered read port of the link memory, then unlinks it. The
// next request can be taken in the cycle after the result is loaded. A finished result waits
// in an output register, so the next request is accepted while it is stalled.
// Reset takes effect at once; no clearing pass follows it.
module doubly_linked_list_engine_top
	import dll_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	dll_req_if.sink   req,
	dll_rsp_if.source rsp
);

	dll_cmd_t   cmd;
	dll_flags_t flags;

	dll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	dll_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.flags         (flags),
		.operation     (req.operation),
		.value         (req.value),
		.position      (req.position),
		.status        (rsp.status),
		.removed_value (rsp.removed_value),
		.length        (rsp.length)
	);

endmodule

// ===== bench/doubly_linked_list_engine_top_test.sv =====
// Self-checking testbench of the doubly linked list engine: directed table, then random requests.
`timescale 1ns / 1ps

module doubly_linked_list_engine_top_test
	import dll_pkg::*;
();

	localparam int RANDOM_ITEMS = 1100;
	localparam int CALM_ITEMS   = 120;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 40;

	// One request item.
	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
		logic [4:0]         position;
	} request_t;

	// One result item.
	typedef struct packed {
		status_t            status;
		logic signed [31:0] removed;
		logic [4:0]         length;
	} reply_t;

	// A row of the directed table; rows with reps above one add 1 to the value per repeat.
	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
		logic [4:0]         position;
		logic [4:0]         reps;
		logic               typed;
		status_t            status;
		logic signed [31:0] removed;
		logic [4:0]         length;
	} step_t;

	localparam int PLAN_ROWS = 15;

	step_t plan [PLAN_ROWS] = '{
		// Removals on the empty list after reset, including a bad position.
		'{OP_POP_HEAD,  32'sd0,        5'd0,  5'd1,  1'b1, STS_EMPTY,   32'sd0,        5'd0},
		'{OP_REMOVE_AT, 32'sd0,        5'd0,  5'd1,  1'b1, STS_EMPTY,   32'sd0,        5'd0},
		// Extreme values at both ends.
		'{OP_PUSH_HEAD, 32'h7fffffff,  5'd0,  5'd1,  1'b1, STS_DONE,    32'sd0,        5'd1},
		'{OP_PUSH_TAIL, 32'h80000000,  5'd31, 5'd1,  1'b1, STS_DONE,    32'sd0,        5'd2},
		// Positions zero and past the end.
		'{OP_REMOVE_AT, 32'sd5,        5'd0,  5'd1,  1'b1, STS_BAD_POS, 32'sd0,        5'd2},
		'{OP_REMOVE_AT, 32'sd5,        5'd31, 5'd1,  1'b1, STS_BAD_POS, 32'sd0,        5'd2},
		// The last position moves the tail, then the only node empties the list.
		'{OP_REMOVE_AT, 32'sd0,        5'd2,  5'd1,  1'b1, STS_DONE,    32'h80000000,  5'd1},
		'{OP_POP_HEAD,  32'sd0,        5'd0,  5'd1,  1'b1, STS_DONE,    32'h7fffffff,  5'd0},
		// Fill the pool with 1 to 16, then try to overfill it and remove past the end.
		'{OP_PUSH_TAIL, 32'sd1,        5'd0,  5'd16, 1'b0, STS_DONE,    32'sd0,        5'd0},
		'{OP_PUSH_HEAD, -32'sd1,       5'd3,  5'd1,  1'b1, STS_FULL,    32'sd0,        5'd16},
		'{OP_PUSH_TAIL, 32'sd9,        5'd0,  5'd1,  1'b1, STS_FULL,    32'sd0,        5'd16},
		'{OP_REMOVE_AT, 32'sd0,        5'd17, 5'd1,  1'b1, STS_BAD_POS, 32'sd0,        5'd16},
		// Deepest walk, then the first position, then a middle one.
		'{OP_REMOVE_AT, 32'sd0,        5'd16, 5'd1,  1'b1, STS_DONE,    32'sd16,       5'd15},
		'{OP_REMOVE_AT, 32'sd0,        5'd1,  5'd1,  1'b1, STS_DONE,    32'sd1,        5'd14},
		'{OP_REMOVE_AT, 32'sd0,        5'd7,  5'd1,  1'b0, STS_DONE,    32'sd0,        5'd0}
	};

	logic clk;
	logic arst_n;

	dll_req_if req_ch ();
	dll_rsp_if rsp_ch ();

	doubly_linked_list_engine_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Values of the list in order from head to tail, as the engine should hold them.
	logic signed [31:0] shadow_list [$];
	// Results owed by the engine, oldest first.
	reply_t replies_due [$];

	int errors;
	int idle_cycles;
	bit quiet;
	int gap_pct;
	int status_seen [4];
	int requests_sent;
	int deepest_walk;
	int longest_list;

	// Clock.
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Applies one request to the shadow list and returns the result it gives.
	function automatic reply_t apply_to_list(request_t rq);
		reply_t r;
		int pos;
		r.status  = STS_DONE;
		r.removed = '0;
		if (rq.op == OP_PUSH_HEAD || rq.op == OP_PUSH_TAIL) begin
			if (shadow_list.size() >= CAPACITY)
				r.status = STS_FULL;
			else if (rq.op == OP_PUSH_HEAD)
				shadow_list.push_front(rq.value);
			else
				shadow_list.push_back(rq.value);
		end else begin
			pos = (rq.op == OP_POP_HEAD) ? 1 : int'(rq.position);
			if (shadow_list.size() == 0) begin
				r.status = STS_EMPTY;
			end else if (pos == 0 || pos > shadow_list.size()) begin
				r.status = STS_BAD_POS;
			end else begin
				r.removed = shadow_list[pos-1];
				shadow_list.delete(pos-1);
			end
		end
		r.length = 5'(shadow_list.size());
		return r;
	endfunction

	// Random value, with the extremes and zero showing up often.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 19))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Opens a gap on the request side, with valid low and junk on the payload.
	task automatic hold_off(int n);
		repeat (n) begin
			@(negedge clk);
			req_ch.valid     = 1'b0;
			req_ch.operation = 2'($urandom);
			req_ch.value     = $urandom;
			req_ch.position  = 5'($urandom);
		end
	endtask

	// Drives one request until it is accepted and records the result it owes.
	task automatic issue_request(request_t rq, bit typed, reply_t fixed);
		reply_t r;
		if (!quiet && gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
			hold_off($urandom_range(1, 19));
		@(negedge clk);
		req_ch.valid     = 1'b1;
		req_ch.operation = rq.op;
		req_ch.value     = rq.value;
		req_ch.position  = rq.position;
		do @(posedge clk); while (!req_ch.ready);
		r = apply_to_list(rq);
		replies_due.push_back(typed ? fixed : r);
		requests_sent++;
		status_seen[r.status]++;
		if (rq.op == OP_REMOVE_AT && r.status == STS_DONE && rq.position > deepest_walk)
			deepest_walk = rq.position;
		if (shadow_list.size() > longest_list)
			longest_list = shadow_list.size();
	endtask

	// Random request that steers the list length toward a target.
	task automatic random_request(output request_t rq, input int target);
		int len;
		bit grow;
		len = shadow_list.size();
		if (len < target)
			grow = ($urandom_range(0, 9) < 7);
		else if (len > target)
			grow = ($urandom_range(0, 9) < 3);
		else
			grow = $urandom_range(0, 1);
		rq.value    = pick_value();
		rq.position = 5'($urandom);
		if (grow) begin
			rq.op = $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
		end else if ($urandom_range(0, 9) < 3) begin
			rq.op = OP_POP_HEAD;
		end else begin
			rq.op = OP_REMOVE_AT;
			// Mostly valid positions, the far end often, and some out of range.
			if (len > 0 && $urandom_range(0, 9) != 0)
				rq.position = ($urandom_range(0, 3) == 0) ? 5'(len) : 5'($urandom_range(1, len));
		end
	endtask

	// Stimulus: reset, directed table, random requests, drain.
	initial begin
		request_t rq;
		reply_t fixed;
		int target;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_PUSH_HEAD;
		req_ch.value     = '0;
		req_ch.position  = '0;
		errors        = 0;
		quiet         = 1'b0;
		gap_pct       = 0;
		requests_sent = 0;
		deepest_walk  = 0;
		longest_list  = 0;
		status_seen   = '{0, 0, 0, 0};
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed table.
		gap_pct = 20;
		foreach (plan[i]) begin
			for (int k = 0; k < plan[i].reps; k++) begin
				rq.op        = plan[i].op;
				rq.value     = plan[i].value + k;
				rq.position  = plan[i].position;
				fixed.status  = plan[i].status;
				fixed.removed = plan[i].removed;
				fixed.length  = plan[i].length;
				issue_request(rq, plan[i].typed, fixed);
			end
		end

		// Random requests; the target length and the gap rate change in phases.
		target = 8;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 80 == 0) begin
				case ($urandom_range(0, 3))
					0: target = 0;
					1: target = CAPACITY;
					default: target = $urandom_range(0, CAPACITY);
				endcase
			end
			if (n % 150 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 8;
					default: gap_pct = 30;
				endcase
			end
			if (n == RANDOM_ITEMS - CALM_ITEMS)
				quiet = 1'b1;
			random_request(rq, target);
			issue_request(rq, 1'b0, fixed);
		end
		@(negedge clk);
		req_ch.valid = 1'b0;

		// Wait for every owed result, then for any stray ones.
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d done, %0d pool full, %0d list empty, %0d bad position.",
			requests_sent, status_seen[STS_DONE], status_seen[STS_FULL],
			status_seen[STS_EMPTY], status_seen[STS_BAD_POS]);
		$display("Longest list %0d nodes, deepest positional removal at %0d.",
			longest_list, deepest_walk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Result side: random stall bursts whose rate changes in phases.
	initial begin
		int stall_left;
		int stall_pct;
		int cycle;
		stall_left   = 0;
		stall_pct    = 0;
		cycle        = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (cycle % 256 == 0) begin
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 5;
					default: stall_pct = 20;
				endcase
			end
			cycle++;
			if (!arst_n) begin
				rsp_ch.ready = 1'b0;
			end else if (quiet) begin
				rsp_ch.ready = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready = 1'b0;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				stall_left   = $urandom_range(1, 19) - 1;
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	// Compare each accepted result with the oldest one owed.
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (replies_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result status %0d removed %0d length %0d", $time,
					rsp_ch.status, rsp_ch.removed_value, rsp_ch.length);
			end else begin
				want = replies_due.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.removed_value !== want.removed
						|| rsp_ch.length !== want.length) begin
					errors++;
					$display("%0t: mismatch status exp %0d got %0d, removed exp %0d got %0d, length exp %0d got %0d",
						$time, want.status, rsp_ch.status, want.removed,
						rsp_ch.removed_value, want.length, rsp_ch.length);
				end
			end
		end
	end

	// Watchdog on cycles with no item moving on either channel.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, %0d results still owed", $time,
				STALL_LIMIT, replies_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule

// ===== filelist.f =====
design/dll_pkg.sv
design/dll_req_if.sv
design/dll_rsp_if.sv
design/dll_datapath.sv
design/dll_ctrl.sv
design/doubly_linked_list_engine_top.sv
bench/doubly_linked_list_engine_top_test.sv
